/* rtl/assert_macros.svh */
// Assertion helpers, sampled on the rising edge of clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

/* rtl/mvsp_pkg.sv */
`default_nettype none
package mvsp_pkg;

	localparam int NUM_VALVES_DEF = 6;
	localparam logic [14:0] MAX_POS_RESET = 15'd20480;
	localparam logic [2:0] SELECT_RESET = 3'd7;

	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_MOVE = 3'd1;
	localparam logic [2:0] CMD_PRESET = 3'd2;
	localparam logic [2:0] CMD_STOP = 3'd3;
	localparam logic [2:0] CMD_QUERY = 3'd4;

	localparam logic [1:0] STAT_ACCEPTED = 2'd0;
	localparam logic [1:0] STAT_REJECTED = 2'd1;
	localparam logic [1:0] STAT_BUSY = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TICK,
		OP_MOVE,
		OP_PRESET,
		OP_STOP,
		OP_QZERO
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [15:0] actual;
		logic [15:0] request;
		logic [2:0] phase;
		logic [15:0] zero_offset;
	} rec_t;

	function automatic logic [3:0] coil_of(input logic [2:0] phase);
		logic [3:0] c;
		unique case (phase)
			3'd0: c = 4'h1;
			3'd1: c = 4'h3;
			3'd2: c = 4'h2;
			3'd3: c = 4'h6;
			3'd4: c = 4'h4;
			3'd5: c = 4'hC;
			3'd6: c = 4'h8;
			3'd7: c = 4'h9;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/mvsp_ram.sv */
`default_nettype none
module mvsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/multi_valve_stepper_positioner.sv */
// Channel   Direction  Handshake                 Payload
// command   in         start, busy               command, valve, target_value,
//                                                actual_value, on_limit
// result    out        done (one-cycle strobe)   coil_pattern, select_lines, running,
//                                                status, rep_actual, rep_target,
//                                                rep_zero_error, rep_phase
// config    in         cfg_valid, cfg_ready      cfg_data (max_position)
//
// In each beat, the record is read from the valve memory in the accept cycle and, for
// executed ticks, moves and presets, modified and written back in the next, while busy is high.
// The result strobe comes the cycle after that, when a new beat may already start.
// Reset is asynchronous; the valve records read as zero until first written.
// The receiver cannot stall, and cfg_ready is always high.
`default_nettype none
module multi_valve_stepper_positioner
	import mvsp_pkg::*;
#(
	parameter int NUM_VALVES = mvsp_pkg::NUM_VALVES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [2:0] command,
	input wire logic [2:0] valve,
	input wire logic signed [15:0] target_value,
	input wire logic signed [15:0] actual_value,
	input wire logic on_limit,
	output logic done,
	output logic [3:0] coil_pattern,
	output logic [2:0] select_lines,
	output logic running,
	output logic [1:0] status,
	output logic signed [15:0] rep_actual,
	output logic signed [15:0] rep_target,
	output logic signed [15:0] rep_zero_error,
	output logic [2:0] rep_phase,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [14:0] cfg_data
);

	`include "assert_macros.svh"

	localparam int AW = (NUM_VALVES > 1) ? $clog2(NUM_VALVES) : 1;

	state_t state_q, state_d;
	logic [14:0] max_q;
	logic run_q, run_d;
	logic [AW-1:0] cur_q, cur_d;
	logic [3:0] coil_q, coil_d;
	logic [2:0] sel_q, sel_d;
	logic [NUM_VALVES-1:0] vld_q;

	op_t op_acc, op_s1;
	logic [1:0] stat_acc, status_s1;
	logic [AW-1:0] raddr, addr_s1;
	logic [15:0] tgt_s1, act_s1;
	logic lim_s1;
	logic rd_vld_s1;
	logic vok, tgt_ok, accept;

	rec_t rd_data, rec, nrec;
	logic we;

	logic done_q;
	logic [1:0] status_q;
	rec_t rep_q;

	assign accept = start && (state_q == ST_IDLE);
	assign vok = int'(valve) < NUM_VALVES;
	assign tgt_ok = !target_value[15] && (target_value[14:0] <= max_q);

	always_comb begin
		op_acc = OP_NONE;
		stat_acc = STAT_ACCEPTED;
		raddr = cur_q;
		unique case (command)
			CMD_TICK: begin
				if (run_q) begin
					op_acc = OP_TICK;
				end
			end
			CMD_MOVE: begin
				if (!vok || !tgt_ok) begin
					stat_acc = STAT_REJECTED;
				end else if (run_q) begin
					stat_acc = STAT_BUSY;
				end else begin
					op_acc = OP_MOVE;
					raddr = valve[AW-1:0];
				end
			end
			CMD_PRESET: begin
				if (!vok) begin
					stat_acc = STAT_REJECTED;
				end else begin
					op_acc = OP_PRESET;
					raddr = valve[AW-1:0];
				end
			end
			CMD_STOP: begin
				op_acc = OP_STOP;
			end
			CMD_QUERY: begin
				if (!vok) begin
					stat_acc = STAT_REJECTED;
					op_acc = OP_QZERO;
				end else begin
					raddr = valve[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	mvsp_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(NUM_VALVES)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(addr_s1),
		.wdata(nrec),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_acc;
			status_s1 <= stat_acc;
			addr_s1 <= raddr;
			tgt_s1 <= target_value;
			act_s1 <= actual_value;
			lim_s1 <= on_limit;
			rd_vld_s1 <= vld_q[raddr];
		end
		if (state_q == ST_EXEC) begin
			status_q <= status_s1;
			rep_q <= (op_s1 == OP_QZERO) ? '0 : nrec;
		end
	end

	assign rec = rd_vld_s1 ? rd_data : '0;

	always_comb begin
		state_d = state_q;
		nrec = rec;
		run_d = run_q;
		cur_d = cur_q;
		coil_d = coil_q;
		sel_d = sel_q;
		we = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				unique case (op_s1)
					OP_TICK: begin
						we = 1'b1;
						sel_d = 3'(cur_q);
						if (rec.actual == rec.request) begin
							run_d = 1'b0;
						end else if ($signed(rec.request) > $signed(rec.actual)) begin
							nrec.phase = rec.phase + 3'd1;
							nrec.actual = rec.actual + 16'd1;
							coil_d = coil_of(nrec.phase);
						end else if (lim_s1) begin
							run_d = 1'b0;
							nrec.zero_offset = rec.actual - rec.request;
						end else begin
							nrec.phase = rec.phase - 3'd1;
							nrec.actual = rec.actual - 16'd1;
							coil_d = coil_of(nrec.phase);
						end
					end
					OP_MOVE: begin
						we = 1'b1;
						nrec.request = tgt_s1;
						cur_d = addr_s1;
						run_d = 1'b1;
					end
					OP_PRESET: begin
						we = 1'b1;
						nrec.request = tgt_s1;
						nrec.actual = act_s1;
						cur_d = addr_s1;
						run_d = 1'b1;
					end
					OP_STOP: begin
						run_d = 1'b0;
					end
					OP_NONE, OP_QZERO: begin
					end
					default: begin
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_q <= MAX_POS_RESET;
			run_q <= 1'b0;
			cur_q <= '0;
			coil_q <= '0;
			sel_q <= SELECT_RESET;
			vld_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			run_q <= run_d;
			cur_q <= cur_d;
			coil_q <= coil_d;
			sel_q <= sel_d;
			done_q <= (state_q == ST_EXEC);
			if (we) begin
				vld_q[addr_s1] <= 1'b1;
			end
			if (cfg_valid) begin
				max_q <= cfg_data;
			end
		end
	end

	assign busy = (state_q == ST_EXEC);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign coil_pattern = coil_q;
	assign select_lines = sel_q;
	assign running = run_q;
	assign status = status_q;
	assign rep_actual = rep_q.actual;
	assign rep_target = rep_q.request;
	assign rep_zero_error = rep_q.zero_offset;
	assign rep_phase = rep_q.phase;

	`ASSERT_CLK(a_accept_execs, accept |=> busy, "Accepted beat did not execute.")
	`ASSERT_CLK(a_done_after_exec, done_q |-> $past(busy), "Result strobe without execution.")
	`ASSERT_NEVER(a_write_idle, we && !busy, "Record written outside execution.")
	`ASSERT_NEVER(a_cur_range, int'(cur_q) >= NUM_VALVES, "Current valve out of range.")
	`ASSERT_CLK(a_run_source, $rose(run_q) |-> $past(op_s1 == OP_MOVE || op_s1 == OP_PRESET),
		"Run started without move or preset.")

endmodule
`default_nettype wire
